>>> sv/bptc_pkg.sv
// shared constants, codes and command/status types for the pressure compensation block
// no dependencies
package bptc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int NUM_COEFS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int RES_W     = 32;
  localparam int DT_W      = 25;
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 23;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int OFF_W     = 36;
  localparam int SENS_W    = 36;
  localparam int SENS_LO_W = 22;
  localparam int ACC_W     = 60;
  localparam int X_W       = 40;

  localparam logic [RES_W-1:0] TEMP_BASE = RES_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS,
    CFG_OFFSET,
    CFG_SENS_TC,
    CFG_OFFSET_TC,
    CFG_REF_TEMP,
    CFG_TEMP_SLOPE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_T_DIFF,
    OP_T_MUL,
    OP_T_FIN,
    OP_P_MUL_OFF,
    OP_P_OFF,
    OP_P_SENS,
    OP_P_MUL_LO,
    OP_P_MUL_HI,
    OP_P_ACC,
    OP_P_SUB,
    OP_P_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } bptc_cmd_t;

  typedef struct packed {
    logic out_free;
  } bptc_stat_t;

endpackage

>>> sv/baro_pressure_temp_compensation.sv
// Barometric first-order compensation: a raw temperature reading (tuser 0) yields
// temperature in 0.01 degree and stores the temperature difference; a raw pressure
// reading (tuser 1) yields pressure in 0.01 mbar from that stored difference.
// One item at a time: a temperature result is loaded through the T_DIFF, T_MUL and T_FIN
// steps after its item is accepted, a pressure result through MUL_OFF, OFF, SENS, MUL_LO,
// MUL_HI, ACC, SUB and FIN, set by the single shared 25x23 multiplier and the step sequence
// around it. The next item can be taken in the cycle after the result is loaded, later while
// a full output register holds back the final step. The input is taken again as soon as
// the sequencer is idle, even while the previous result still waits in the output register.
// The user writes calibration words through the cfg port only while no item is in flight;
// the block does not enforce this. Top level; depends on bptc_pkg, bptc_ctrl, bptc_datapath
module baro_pressure_temp_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bptc_pkg::COEF_W-1:0]         cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bptc_pkg::RAW_W-1:0]          s_axis_tdata,   // raw_reading
  input  logic                                s_axis_tuser,   // mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bptc_pkg::RES_W-1:0]          m_axis_tdata,   // result_value
  output logic                                m_axis_tuser    // result_kind
);
  import bptc_pkg::*;

  bptc_cmd_t  cmd;
  bptc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bptc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  bptc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> sv/bptc_datapath.sv
// datapath: calibration registers, shared multiplier, working registers, output register
// depends on bptc_pkg
module bptc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bptc_pkg::COEF_W-1:0]         cfg_data_i,
  input  logic [bptc_pkg::RAW_W-1:0]          s_axis_tdata,   // raw_reading
  input  logic                                s_axis_tuser,   // mode
  input  bptc_pkg::bptc_cmd_t                 cmd_i,
  output bptc_pkg::bptc_stat_t                stat_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bptc_pkg::RES_W-1:0]          m_axis_tdata,   // result_value
  output logic                                m_axis_tuser    // result_kind
);
  import bptc_pkg::*;

  logic [COEF_W-1:0] coef_q [NUM_COEFS];

  logic [RAW_W-1:0]  raw_q;
  logic              mode_q;
  logic [DT_W-1:0]   dt_q;
  logic [PROD_W-1:0] prod_q;
  logic [OFF_W-1:0]  off_q;
  logic [SENS_W-1:0] sens_q;
  logic [ACC_W-1:0]  acc_q;
  logic [X_W-1:0]    x_q;
  logic              out_valid_q;
  logic [RES_W-1:0]  out_data_q;
  logic              out_kind_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;

  logic [PROD_W-1:0] prod_r7, prod_r8, prod_r23;
  logic [ACC_W-1:0]  acc_r21;
  logic [X_W-1:0]    x_r15;
  logic [DT_W-1:0]   dt_new;
  logic [OFF_W-1:0]  off_new;
  logic [SENS_W-1:0] sens_new;
  logic [X_W-1:0]    x_new;
  logic [RES_W-1:0]  temp_res, pres_res;

  // calibration registers, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= '0;
    end else if (cfg_valid_i && (int'(cfg_index_i) < NUM_COEFS)) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = $signed(dt_q);
    mul_b  = $signed({(MUL_B_W-COEF_W)'(0), coef_q[CFG_TEMP_SLOPE]});
    mul_en = 1'b0;
    unique case (cmd_i.op)
      OP_T_MUL: begin
        mul_en = 1'b1;
      end
      OP_P_MUL_OFF: begin
        mul_b  = $signed({(MUL_B_W-COEF_W)'(0), coef_q[CFG_OFFSET_TC]});
        mul_en = 1'b1;
      end
      OP_P_OFF: begin
        mul_b  = $signed({(MUL_B_W-COEF_W)'(0), coef_q[CFG_SENS_TC]});
        mul_en = 1'b1;
      end
      OP_P_MUL_LO: begin
        mul_a  = $signed({1'b0, raw_q});
        mul_b  = $signed({1'b0, sens_q[SENS_LO_W-1:0]});
        mul_en = 1'b1;
      end
      OP_P_MUL_HI: begin
        mul_a  = $signed({1'b0, raw_q});
        mul_b  = $signed({{(MUL_B_W-SENS_W+SENS_LO_W){sens_q[SENS_W-1]}},
                          sens_q[SENS_W-1:SENS_LO_W]});
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divide by powers of two toward zero: add bias when negative, then take upper bits
  assign prod_r7  = prod_q + {(PROD_W-7)'(0),  {7{prod_q[PROD_W-1]}}};
  assign prod_r8  = prod_q + {(PROD_W-8)'(0),  {8{prod_q[PROD_W-1]}}};
  assign prod_r23 = prod_q + {(PROD_W-23)'(0), {23{prod_q[PROD_W-1]}}};
  assign acc_r21  = acc_q  + {(ACC_W-21)'(0),  {21{acc_q[ACC_W-1]}}};
  assign x_r15    = x_q    + {(X_W-15)'(0),    {15{x_q[X_W-1]}}};

  assign dt_new   = {1'b0, raw_q} - {1'b0, coef_q[CFG_REF_TEMP], 8'b0};
  assign off_new  = {(OFF_W-COEF_W-16)'(0), coef_q[CFG_OFFSET], 16'b0} + prod_r7[OFF_W+6:7];
  assign sens_new = {(SENS_W-COEF_W-15)'(0), coef_q[CFG_SENS], 15'b0} + prod_r8[SENS_W+7:8];
  assign x_new    = {acc_r21[ACC_W-1], acc_r21[ACC_W-1:21]}
                  - {{(X_W-OFF_W){off_q[OFF_W-1]}}, off_q};
  assign temp_res = TEMP_BASE + {{(RES_W-PROD_W+23){prod_r23[PROD_W-1]}},
                                 prod_r23[PROD_W-1:23]};
  assign pres_res = {{(RES_W-X_W+15){x_r15[X_W-1]}}, x_r15[X_W-1:15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= '0;
    end else if (cmd_i.op == OP_T_DIFF) begin
      dt_q <= dt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      raw_q  <= s_axis_tdata;
      mode_q <= s_axis_tuser;
    end
    if (mul_en) prod_q <= mul_p;
    if (cmd_i.op == OP_P_OFF) off_q <= off_new;
    if (cmd_i.op == OP_P_SENS) sens_q <= sens_new;
    if (cmd_i.op == OP_P_MUL_HI) acc_q <= {(ACC_W-PROD_W)'(0), prod_q};
    if (cmd_i.op == OP_P_ACC) acc_q <= acc_q + {prod_q[ACC_W-23:0], 22'b0};
    if (cmd_i.op == OP_P_SUB) x_q <= x_new;
    if (cmd_i.op == OP_T_FIN) begin
      out_data_q <= temp_res;
      out_kind_q <= mode_q;
    end
    if (cmd_i.op == OP_P_FIN) begin
      out_data_q <= pres_res;
      out_kind_q <= mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.op == OP_T_FIN) || (cmd_i.op == OP_P_FIN)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser    = out_kind_q;

endmodule

>>> sv/bptc_ctrl.sv
// controller: sequences the datapath through temperature or pressure steps
// depends on bptc_pkg
module bptc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic                  s_axis_tuser,   // mode
  input  bptc_pkg::bptc_stat_t  stat_i,
  output bptc_pkg::bptc_cmd_t   cmd_o
);
  import bptc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_T_DIFF    = 4'd1;
  localparam logic [3:0] S_T_MUL     = 4'd2;
  localparam logic [3:0] S_T_FIN     = 4'd3;
  localparam logic [3:0] S_P_MUL_OFF = 4'd4;
  localparam logic [3:0] S_P_OFF     = 4'd5;
  localparam logic [3:0] S_P_SENS    = 4'd6;
  localparam logic [3:0] S_P_MUL_LO  = 4'd7;
  localparam logic [3:0] S_P_MUL_HI  = 4'd8;
  localparam logic [3:0] S_P_ACC     = 4'd9;
  localparam logic [3:0] S_P_SUB     = 4'd10;
  localparam logic [3:0] S_P_FIN     = 4'd11;

  logic [3:0] state_q, state_d;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.op = OP_LOAD;
          state_d  = s_axis_tuser ? S_P_MUL_OFF : S_T_DIFF;
        end
      end
      S_T_DIFF:    begin cmd_o.op = OP_T_DIFF;    state_d = S_T_MUL;    end
      S_T_MUL:     begin cmd_o.op = OP_T_MUL;     state_d = S_T_FIN;    end
      S_T_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_T_FIN;
          state_d  = S_IDLE;
        end
      end
      S_P_MUL_OFF: begin cmd_o.op = OP_P_MUL_OFF; state_d = S_P_OFF;    end
      S_P_OFF:     begin cmd_o.op = OP_P_OFF;     state_d = S_P_SENS;   end
      S_P_SENS:    begin cmd_o.op = OP_P_SENS;    state_d = S_P_MUL_LO; end
      S_P_MUL_LO:  begin cmd_o.op = OP_P_MUL_LO;  state_d = S_P_MUL_HI; end
      S_P_MUL_HI:  begin cmd_o.op = OP_P_MUL_HI;  state_d = S_P_ACC;    end
      S_P_ACC:     begin cmd_o.op = OP_P_ACC;     state_d = S_P_SUB;    end
      S_P_SUB:     begin cmd_o.op = OP_P_SUB;     state_d = S_P_FIN;    end
      S_P_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_P_FIN;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/bptc_checker.sv
// port-level checks for the pressure compensation block, bound to the top level
// depends on bptc_pkg and baro_pressure_temp_compensation
module bptc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bptc_pkg::RES_W-1:0]      m_axis_tdata,
  input logic                            m_axis_tuser
);
  import bptc_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // stalled result payload stays put
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken while busy");

  // a new result must not appear too early after its input is accepted
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
    else $error("result appeared too early");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
